// ----- hw/rtl/tam_pkg.sv -----
`default_nettype none
package tam_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WIDE_BITS   = SAMPLE_BITS + 4;
    localparam int TIME_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [WIDE_BITS-1:0]   t_wide;
    typedef logic [TIME_BITS-1:0]          t_time;
    typedef logic [1:0]                    t_level;
    typedef logic [2:0]                    t_mask;
    typedef logic [CFG_IDX_BITS-1:0]       t_cfg_idx;

    localparam t_level LVL_NONE = 2'd0;
    localparam t_level LVL_WARN = 2'd1;
    localparam t_level LVL_CRIT = 2'd2;

    localparam t_cfg_idx REG_TEMP_LIMIT = 2'd0;
    localparam t_cfg_idx REG_VIB_LIMIT  = 2'd1;
    localparam t_cfg_idx REG_CURR_LIMIT = 2'd2;

    localparam t_sample LIMIT_RESET = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // per-channel verdict
    typedef struct packed {
        logic crit;   // above limit
        logic warn;   // above 80%, or critical
        logic block;  // above 90%, holds the alarm
    } t_judge;

endpackage
`default_nettype wire

// ----- hw/rtl/tam_in_if.sv -----
`default_nettype none
interface tam_in_if;
    logic             valid;
    logic             ready;
    tam_pkg::t_sample temp_sample;
    logic             temp_ok;
    tam_pkg::t_sample vib_sample;
    logic             vib_ok;
    tam_pkg::t_sample curr_sample;
    logic             curr_ok;
    tam_pkg::t_time   now_ms;

    modport source (
        output valid, temp_sample, temp_ok, vib_sample, vib_ok, curr_sample, curr_ok,
               now_ms,
        input  ready
    );
    modport sink (
        input  valid, temp_sample, temp_ok, vib_sample, vib_ok, curr_sample, curr_ok,
               now_ms,
        output ready
    );
endinterface
`default_nettype wire

// ----- hw/rtl/tam_out_if.sv -----
`default_nettype none
interface tam_out_if;
    logic            valid;
    logic            ready;
    logic            alarm_on;
    tam_pkg::t_level alarm_level;
    tam_pkg::t_mask  alarm_sources;
    tam_pkg::t_time  alarm_duration;
    logic            trip_pulse;
    logic            recover_pulse;

    modport source (
        output valid, alarm_on, alarm_level, alarm_sources, alarm_duration, trip_pulse,
               recover_pulse,
        input  ready
    );
    modport sink (
        input  valid, alarm_on, alarm_level, alarm_sources, alarm_duration, trip_pulse,
               recover_pulse,
        output ready
    );
endinterface
`default_nettype wire

// ----- hw/rtl/tam_judge.sv -----
`default_nettype none
module tam_judge (
    input  wire tam_pkg::t_sample i_sample,
    input  wire tam_pkg::t_sample i_limit,
    input  wire logic             i_ok,
    output tam_pkg::t_judge       o_res
);
    import tam_pkg::*;

    t_wide x;
    t_wide l;
    t_wide x5;
    t_wide l4;
    t_wide x10;
    t_wide l9;

    always_comb begin
        x   = t_wide'(i_sample);
        l   = t_wide'(i_limit);
        x5  = (x <<< 2) + x;
        l4  = l <<< 2;
        x10 = (x <<< 3) + (x <<< 1);
        l9  = (l <<< 3) + l;
        o_res.crit  = i_ok && (x > l);
        o_res.warn  = i_ok && ((x > l) || (x5 > l4));
        o_res.block = i_ok && (x10 > l9);
    end
endmodule
`default_nettype wire

// ----- hw/rtl/three_channel_alarm_monitor_core.sv -----
// three-channel threshold alarm with hysteresis
//
// i_smp (sink) takes one beat per sampling period: temperature, vibration and
// current samples with their valid flags and a millisecond timestamp. o_alm
// (source) gives one result beat per sample beat, in order. limits are written
// through i_cfg_we / i_cfg_idx / i_cfg_data (0 temperature, 1 vibration, 2
// current) by the user only while no beat is in flight, unchecked by the block.
//
// a beat is captured in an input register, classified against the three
// limits and folded into the alarm state on the way to the output register.
// the sample beat passes the input register and then the output register.
// throughput: one beat per cycle while the output is not stalled; the state update is the loop.
// a stalled output keeps its beat; one more sample beat waits in the input
// register, then i_smp.ready drops until the output is taken.
// reset clears the alarm state, sets all limits to the positive maximum and
// empties both registers.
`default_nettype none
module three_channel_alarm_monitor_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tam_in_if.sink                 i_smp,
    tam_out_if.source              o_alm,
    input  wire logic              i_cfg_we,
    input  wire tam_pkg::t_cfg_idx i_cfg_idx,
    input  wire tam_pkg::t_sample  i_cfg_data
);
    import tam_pkg::*;

    t_sample r_temp_limit;
    t_sample r_vib_limit;
    t_sample r_curr_limit;

    // input register
    logic    r_in_valid;
    t_sample r_temp;
    logic    r_temp_ok;
    t_sample r_vib;
    logic    r_vib_ok;
    t_sample r_curr;
    logic    r_curr_ok;
    t_time   r_now;

    // alarm state
    logic   r_tripped, n_tripped;
    t_level r_level, n_level;
    t_mask  r_sources, n_sources;
    t_time  r_trip_time, n_trip_time;
    t_time  r_duration, n_duration;

    // output register
    logic r_out_valid;
    logic r_trip_p, n_trip_p;
    logic r_rec_p, n_rec_p;

    t_judge j_temp, j_vib, j_curr;
    logic   advance;
    logic   any_crit, any_warn, any_block;
    t_level lvl;
    t_mask  mask;

    tam_judge u_judge_temp (
        .i_sample (r_temp), .i_limit (r_temp_limit), .i_ok (r_temp_ok), .o_res (j_temp)
    );
    tam_judge u_judge_vib (
        .i_sample (r_vib), .i_limit (r_vib_limit), .i_ok (r_vib_ok), .o_res (j_vib)
    );
    tam_judge u_judge_curr (
        .i_sample (r_curr), .i_limit (r_curr_limit), .i_ok (r_curr_ok), .o_res (j_curr)
    );

    assign advance     = r_in_valid && (!r_out_valid || o_alm.ready);
    assign i_smp.ready = !r_in_valid || advance;

    always_comb begin
        any_crit  = j_temp.crit || j_vib.crit || j_curr.crit;
        any_warn  = j_temp.warn || j_vib.warn || j_curr.warn;
        any_block = j_temp.block || j_vib.block || j_curr.block;
        mask      = {j_curr.warn, j_vib.warn, j_temp.warn};
        if (any_crit) begin
            lvl = LVL_CRIT;
        end else if (any_warn) begin
            lvl = LVL_WARN;
        end else begin
            lvl = LVL_NONE;
        end
    end

    always_comb begin
        n_tripped   = r_tripped;
        n_level     = r_level;
        n_sources   = r_sources;
        n_trip_time = r_trip_time;
        n_duration  = r_duration;
        n_trip_p    = 1'b0;
        n_rec_p     = 1'b0;
        if (!r_tripped) begin
            if (any_crit) begin
                n_tripped   = 1'b1;
                n_level     = lvl;
                n_sources   = mask;
                n_trip_time = r_now;
                n_duration  = '0;
                n_trip_p    = 1'b1;
            end
        end else begin
            n_level    = lvl;
            n_sources  = mask;
            n_duration = r_now - r_trip_time;
            if (!any_block) begin
                n_tripped = 1'b0;
                n_level   = LVL_NONE;
                n_sources = '0;
                n_rec_p   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_limit <= LIMIT_RESET;
            r_vib_limit  <= LIMIT_RESET;
            r_curr_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TEMP_LIMIT: r_temp_limit <= i_cfg_data;
                REG_VIB_LIMIT:  r_vib_limit  <= i_cfg_data;
                REG_CURR_LIMIT: r_curr_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_valid <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.ready && i_smp.valid) begin
            r_temp    <= i_smp.temp_sample;
            r_temp_ok <= i_smp.temp_ok;
            r_vib     <= i_smp.vib_sample;
            r_vib_ok  <= i_smp.vib_ok;
            r_curr    <= i_smp.curr_sample;
            r_curr_ok <= i_smp.curr_ok;
            r_now     <= i_smp.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tripped   <= 1'b0;
            r_level     <= LVL_NONE;
            r_sources   <= '0;
            r_trip_time <= '0;
            r_duration  <= '0;
            r_out_valid <= 1'b0;
            r_trip_p    <= 1'b0;
            r_rec_p     <= 1'b0;
        end else begin
            if (advance) begin
                r_tripped   <= n_tripped;
                r_level     <= n_level;
                r_sources   <= n_sources;
                r_trip_time <= n_trip_time;
                r_duration  <= n_duration;
                r_trip_p    <= n_trip_p;
                r_rec_p     <= n_rec_p;
                r_out_valid <= 1'b1;
            end else if (o_alm.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the output beat shows the state left by its own sample
    assign o_alm.valid          = r_out_valid;
    assign o_alm.alarm_on       = r_tripped;
    assign o_alm.alarm_level    = r_level;
    assign o_alm.alarm_sources  = r_sources;
    assign o_alm.alarm_duration = r_duration;
    assign o_alm.trip_pulse     = r_trip_p;
    assign o_alm.recover_pulse  = r_rec_p;
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
module testbench;
    import tam_pkg::*;

    typedef struct packed {
        logic    t_ok;
        t_sample t;
        logic    v_ok;
        t_sample v;
        logic    c_ok;
        t_sample c;
        t_time   now;
    } sample_rec_t;

    typedef struct packed {
        logic   on;
        t_level level;
        t_mask  sources;
        t_time  duration;
        logic   trip;
        logic   recover;
    } alarm_rec_t;

    // tracks the alarm state and holds the results still owed by the block
    class alarm_tracker;
        t_sample    limit_temp = LIMIT_RESET;
        t_sample    limit_vib  = LIMIT_RESET;
        t_sample    limit_curr = LIMIT_RESET;
        logic       tripped    = 1'b0;
        t_level     level      = LVL_NONE;
        t_mask      sources    = '0;
        t_time      trip_at    = '0;
        t_time      duration   = '0;
        alarm_rec_t pending[$];
        int         errors     = 0;
        int         checked    = 0;
        int         trips      = 0;
        int         recoveries = 0;

        function void set_limit(t_cfg_idx idx, t_sample val);
            case (idx)
                REG_TEMP_LIMIT: limit_temp = val;
                REG_VIB_LIMIT:  limit_vib  = val;
                REG_CURR_LIMIT: limit_curr = val;
                default: ;
            endcase
        endfunction

        function void grade(logic ok, t_sample x, t_sample lim, int bitn,
                            inout t_level lvl, inout t_mask mask, inout logic hold);
            int xv;
            int lv;
            xv = x;
            lv = lim;
            if (!ok) return;
            if (xv > lv) begin
                mask[bitn] = 1'b1;
                lvl = LVL_CRIT;
            end else if (5 * xv > 4 * lv) begin
                mask[bitn] = 1'b1;
                if (lvl == LVL_NONE) lvl = LVL_WARN;
            end
            if (10 * xv > 9 * lv) hold = 1'b1;
        endfunction

        function void take_sample(sample_rec_t s);
            t_level     lvl;
            t_mask      mask;
            logic       hold;
            alarm_rec_t r;
            lvl  = LVL_NONE;
            mask = '0;
            hold = 1'b0;
            grade(s.t_ok, s.t, limit_temp, 0, lvl, mask, hold);
            grade(s.v_ok, s.v, limit_vib,  1, lvl, mask, hold);
            grade(s.c_ok, s.c, limit_curr, 2, lvl, mask, hold);
            r.trip    = 1'b0;
            r.recover = 1'b0;
            if (!tripped) begin
                if (lvl == LVL_CRIT) begin
                    tripped  = 1'b1;
                    level    = lvl;
                    sources  = mask;
                    trip_at  = s.now;
                    duration = '0;
                    r.trip   = 1'b1;
                    trips++;
                end
            end else begin
                level    = lvl;
                sources  = mask;
                duration = s.now - trip_at;
                // every valid channel at or below 90% releases the alarm
                if (!hold) begin
                    tripped   = 1'b0;
                    level     = LVL_NONE;
                    sources   = '0;
                    r.recover = 1'b1;
                    recoveries++;
                end
            end
            r.on       = tripped;
            r.level    = level;
            r.sources  = sources;
            r.duration = duration;
            pending.push_back(r);
        endfunction

        function void compare_alarm(alarm_rec_t got);
            alarm_rec_t want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result beat %0d arrived with nothing outstanding", checked);
                return;
            end
            want = pending.pop_front();
            if (got.on !== want.on || got.level !== want.level ||
                got.sources !== want.sources || got.duration !== want.duration ||
                got.trip !== want.trip || got.recover !== want.recover) begin
                errors++;
                if (errors <= 10) begin
                    $display("result beat %0d: want on=%0b lvl=%0d src=%b dur=%0d trip=%0b rec=%0b",
                             checked, want.on, want.level, want.sources, want.duration,
                             want.trip, want.recover);
                    $display("    got  on=%0b lvl=%0d src=%b dur=%0d trip=%0b rec=%0b",
                             got.on, got.level, got.sources, got.duration,
                             got.trip, got.recover);
                end
            end
        endfunction

        function void close_out();
            if (pending.size() != 0) begin
                errors++;
                $display("%0d result beats never arrived", pending.size());
            end
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_sample  i_cfg_data;
    bit       calm = 1'b0;
    t_time    clock_ms = '0;
    int       phases = 0;

    alarm_tracker tracker = new;

    tam_in_if  smp();
    tam_out_if alm();

    three_channel_alarm_monitor_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp),
        .o_alm      (alm),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: random stall bursts, none once the run turns calm
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                alm.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                alm.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        alarm_rec_t got;
        sample_rec_t s;
        if (i_rst_n) begin
            if (alm.valid && alm.ready) begin
                got.on       = alm.alarm_on;
                got.level    = alm.alarm_level;
                got.sources  = alm.alarm_sources;
                got.duration = alm.alarm_duration;
                got.trip     = alm.trip_pulse;
                got.recover  = alm.recover_pulse;
                tracker.compare_alarm(got);
            end
            if (smp.valid && smp.ready) begin
                s.t_ok = smp.temp_ok;
                s.t    = smp.temp_sample;
                s.v_ok = smp.vib_ok;
                s.v    = smp.vib_sample;
                s.c_ok = smp.curr_ok;
                s.c    = smp.curr_sample;
                s.now  = smp.now_ms;
                tracker.take_sample(s);
            end
        end
    end

    function automatic sample_rec_t mk_sample(logic to, int t, logic vo, int v,
                                              logic co, int c, t_time now);
        sample_rec_t s;
        s.t_ok = to;
        s.t    = t_sample'(t);
        s.v_ok = vo;
        s.v    = t_sample'(v);
        s.c_ok = co;
        s.c    = t_sample'(c);
        s.now  = now;
        return s;
    endfunction

    // values mostly at the 80%, 90% and 100% boundaries of a limit
    function automatic t_sample pick_sample(t_sample lim, bit quiet);
        int l;
        int v;
        int q;
        l = lim;
        q = (9 * l) / 10;
        if (q * 10 > 9 * l) q = q - 1;
        if (quiet) begin
            v = q - int'($urandom_range(0, 3));
        end else begin
            case ($urandom_range(0, 9))
                0, 1:    v = int'(t_sample'($urandom));
                2:       v = (4 * l) / 5 + int'($urandom_range(0, 4)) - 2;
                3, 4:    v = q + int'($urandom_range(0, 4)) - 2;
                5, 6:    v = l + int'($urandom_range(0, 4)) - 2;
                7:       v = l / 2 + int'($urandom_range(0, 200)) - 100;
                8:       v = $urandom_range(0, 1) ? 32767 : -32768;
                default: v = l + int'($urandom_range(1, 3000));
            endcase
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return t_sample'(v);
    endfunction

    task automatic send_sample(sample_rec_t s);
        smp.valid       <= 1'b1;
        smp.temp_ok     <= s.t_ok;
        smp.temp_sample <= s.t;
        smp.vib_ok      <= s.v_ok;
        smp.vib_sample  <= s.v;
        smp.curr_ok     <= s.c_ok;
        smp.curr_sample <= s.c;
        smp.now_ms      <= s.now;
        do @(posedge i_clk); while (!smp.ready);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding result drain
    task automatic drain();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limits(int t, int v, int c);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TEMP_LIMIT;
        i_cfg_data <= t_sample'(t);
        tracker.set_limit(REG_TEMP_LIMIT, t_sample'(t));
        @(posedge i_clk);
        i_cfg_idx  <= REG_VIB_LIMIT;
        i_cfg_data <= t_sample'(v);
        tracker.set_limit(REG_VIB_LIMIT, t_sample'(v));
        @(posedge i_clk);
        i_cfg_idx  <= REG_CURR_LIMIT;
        i_cfg_data <= t_sample'(c);
        tracker.set_limit(REG_CURR_LIMIT, t_sample'(c));
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        phases++;
    endtask

    task automatic run_random(int n);
        sample_rec_t s;
        bit          quiet;
        for (int i = 0; i < n; i++) begin
            quiet  = ($urandom_range(0, 9) < 3);
            s.t_ok = ($urandom_range(0, 7) != 0);
            s.t    = pick_sample(tracker.limit_temp, quiet);
            s.v_ok = ($urandom_range(0, 7) != 0);
            s.v    = pick_sample(tracker.limit_vib, quiet);
            s.c_ok = ($urandom_range(0, 7) != 0);
            s.c    = pick_sample(tracker.limit_curr, quiet);
            if ($urandom_range(0, 39) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, 50);
            s.now = clock_ms;
            send_sample(s);
            sender_gap();
        end
    endtask

    initial begin
        sample_rec_t directed[$];
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_TEMP_LIMIT;
        i_cfg_data      <= '0;
        smp.valid       <= 1'b0;
        smp.temp_ok     <= 1'b0;
        smp.temp_sample <= '0;
        smp.vib_ok      <= 1'b0;
        smp.vib_sample  <= '0;
        smp.curr_ok     <= 1'b0;
        smp.curr_sample <= '0;
        smp.now_ms      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limits: full-scale samples only reach warning
        send_sample(mk_sample(1, 32767, 1, 32767, 1, 32767, 5));
        drain();

        write_limits(1000, 1000, 1000);
        directed.push_back(mk_sample(0, 32767, 0, 32767, 0, 32767, 10));
        directed.push_back(mk_sample(1, 800, 1, 800, 1, 800, 20));
        directed.push_back(mk_sample(1, 801, 1, 901, 1, 1000, 30));
        directed.push_back(mk_sample(1, 1001, 1, 900, 1, -32768, 100));
        directed.push_back(mk_sample(1, 1001, 1, 850, 1, 950, 150));
        directed.push_back(mk_sample(1, 901, 1, 0, 1, 0, 200));
        directed.push_back(mk_sample(1, 900, 1, 900, 1, 900, 260));
        directed.push_back(mk_sample(1, 0, 1, 0, 1, 0, 300));
        directed.push_back(mk_sample(1, 0, 1, 0, 1, 32767, 32'hFFFF_FFF0));
        // invalid channel above limit must not hold the alarm; duration wraps
        directed.push_back(mk_sample(1, 500, 1, 0, 0, 32767, 32'h0000_0010));
        directed.push_back(mk_sample(0, 32767, 1, -32768, 0, 32767, 32'h0000_0020));
        foreach (directed[i]) begin
            send_sample(directed[i]);
            sender_gap();
        end
        drain();

        write_limits(-32768, 32767, 0);
        directed.delete();
        directed.push_back(mk_sample(1, -32768, 0, 0, 0, 0, 40));
        directed.push_back(mk_sample(1, -32767, 0, 0, 0, 0, 50));
        directed.push_back(mk_sample(1, -32768, 1, 32767, 1, 0, 60));
        directed.push_back(mk_sample(0, 0, 1, 0, 1, 1, 70));
        directed.push_back(mk_sample(1, -32768, 1, 0, 1, 0, 80));
        directed.push_back(mk_sample(1, -32768, 1, 26214, 1, -5, 90));
        foreach (directed[i]) begin
            send_sample(directed[i]);
            sender_gap();
        end
        drain();

        write_limits(32767, 32767, 32767);
        run_random(204);
        drain();
        write_limits(1000, 2000, 500);
        run_random(204);
        drain();
        write_limits(-32768, 0, 32767);
        run_random(204);
        drain();
        write_limits(int'(t_sample'($urandom)), int'(t_sample'($urandom)),
                     int'(t_sample'($urandom)));
        run_random(204);
        drain();
        write_limits(-1000, -20000, 100);
        clock_ms = 32'hFFFF_F000;
        run_random(204);
        drain();
        write_limits(0, 0, 0);
        run_random(204);
        drain();
        write_limits($urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(1, 300));
        run_random(204);
        drain();
        write_limits(int'(t_sample'($urandom)), $urandom_range(0, 32767),
                     -int'($urandom_range(0, 32768)));
        calm = 1'b1;
        run_random(204);
        drain();

        repeat (4) @(posedge i_clk);
        tracker.close_out();
        $display("checked %0d result beats over %0d limit settings", tracker.checked, phases);
        $display("alarm tripped %0d times and recovered %0d times, %0d mismatches",
                 tracker.trips, tracker.recoveries, tracker.errors);
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #1000000;
        $display("timed out with %0d result beats outstanding", tracker.pending.size());
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/tam_pkg.sv
hw/rtl/tam_in_if.sv
hw/rtl/tam_out_if.sv
hw/rtl/tam_judge.sv
hw/rtl/three_channel_alarm_monitor_core.sv
dv/testbench.sv
